FILE: hw/rtl/rcp_pkg.sv
package rcp_pkg;

    // geometry constants
    localparam int SCREEN_HEIGHT  = 512;
    localparam int TEX_LOG2       = 6;
    localparam int DIST_FRAC_BITS = 5;

    // field widths
    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int DIST_W  = 16;
    localparam int TCOL_W  = 6;
    localparam int FACE_W  = 2;
    localparam int COLOR_W = 24;
    localparam int TROW_W  = 6;

    // wall height numerator and derived widths
    localparam int HD_NUM_VAL = SCREEN_HEIGHT << DIST_FRAC_BITS;
    localparam int FULLH_W    = $clog2(HD_NUM_VAL + 1);
    localparam int H_W        = $clog2(SCREEN_HEIGHT + 1);
    localparam int K_W        = ((FULLH_W > ROW_W) ? FULLH_W : ROW_W) + 2;

    // divider pipeline shape
    localparam int HD_STEPS  = 2;
    localparam int HD_STAGES = (FULLH_W + HD_STEPS - 1) / HD_STEPS;
    localparam int TD_STEPS  = 2;
    localparam int TD_STAGES = (TEX_LOG2 + TD_STEPS - 1) / TD_STEPS;

    localparam logic [FULLH_W-1:0] HD_NUM = FULLH_W'(HD_NUM_VAL);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CEILING_COLOR = 1'b0,
        CFG_FLOOR_COLOR   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SRC_CEILING = 2'd0,
        SRC_FLOOR   = 2'd1,
        SRC_WALL    = 2'd2,
        SRC_NONE    = 2'd3
    } src_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [DIST_W-1:0] distance;
        logic [TCOL_W-1:0] tex_col;
        logic [FACE_W-1:0] wall_face;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [TCOL_W-1:0]  tex_col;
        logic [FACE_W-1:0]  face;
        logic [DIST_W-1:0]  divisor;
        logic [FULLH_W-1:0] num;
        logic [FULLH_W-1:0] quo;
        logic [DIST_W-1:0]  rem;
    } hdiv_t;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [TCOL_W-1:0]  tex_col;
        logic [FACE_W-1:0]  face;
        logic [FULLH_W-1:0] full_h;
        logic [H_W-1:0]     vis_h;
        logic [FULLH_W-1:0] skip;
        logic [H_W-1:0]     offset;
    } geo_t;

    typedef struct packed {
        logic [COL_W-1:0]    column;
        logic [ROW_W-1:0]    row;
        logic [TCOL_W-1:0]   tex_col;
        logic [FACE_W-1:0]   face;
        src_t                src;
        logic [FULLH_W-1:0]  full_h;
        logic [FULLH_W-1:0]  rem;
        logic [TEX_LOG2-1:0] quo;
        logic                sat;
    } tdiv_t;

    typedef struct packed {
        logic [COL_W-1:0]   pixel_column;
        logic [ROW_W-1:0]   pixel_row;
        src_t               source;
        logic [COLOR_W-1:0] pixel_color;
        logic [TROW_W-1:0]  tex_row;
        logic [TCOL_W-1:0]  tex_col_out;
        logic [FACE_W-1:0]  face_out;
    } out_item_t;

endpackage

FILE: hw/rtl/rcp_in_if.sv
interface rcp_in_if;
    import rcp_pkg::*;

    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [DIST_W-1:0] distance;
    logic [TCOL_W-1:0] tex_col;
    logic [FACE_W-1:0] wall_face;

    modport source (
        output valid, column, row, distance, tex_col, wall_face,
        input  ready
    );

    modport sink (
        input  valid, column, row, distance, tex_col, wall_face,
        output ready
    );

endinterface

FILE: hw/rtl/rcp_out_if.sv
interface rcp_out_if;
    import rcp_pkg::*;

    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   pixel_column;
    logic [ROW_W-1:0]   pixel_row;
    src_t               pixel_source;
    logic [COLOR_W-1:0] pixel_color;
    logic [TROW_W-1:0]  tex_row;
    logic [TCOL_W-1:0]  tex_col_out;
    logic [FACE_W-1:0]  face_out;

    modport source (
        output valid, pixel_column, pixel_row, pixel_source, pixel_color, tex_row,
               tex_col_out, face_out,
        input  ready
    );

    modport sink (
        input  valid, pixel_column, pixel_row, pixel_source, pixel_color, tex_row,
               tex_col_out, face_out,
        output ready
    );

endinterface

FILE: hw/rtl/rcp_height_div.sv
module rcp_height_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  rcp_pkg::in_item_t in_item,
    output logic             out_valid,
    output rcp_pkg::hdiv_t   out_item
);
    import rcp_pkg::*;

    // one restoring step: bring down the next numerator bit, try the subtract
    function automatic hdiv_t hdiv_step(input hdiv_t x);
        logic [DIST_W:0] r2;
        logic            ge;
        hdiv_t           y;
        y     = x;
        r2    = {x.rem, x.num[FULLH_W-1]};
        ge    = (r2 >= {1'b0, x.divisor});
        y.rem = ge ? DIST_W'(r2 - {1'b0, x.divisor}) : r2[DIST_W-1:0];
        y.quo = {x.quo[FULLH_W-2:0], ge};
        y.num = {x.num[FULLH_W-2:0], 1'b0};
        return y;
    endfunction

    hdiv_t                stage_reg  [HD_STAGES];
    hdiv_t                stage_next [HD_STAGES];
    logic [HD_STAGES-1:0] valid_reg;
    logic [HD_STAGES-1:0] valid_next;
    hdiv_t                entry;

    always_comb
    begin
        entry.column  = in_item.column;
        entry.row     = in_item.row;
        entry.tex_col = in_item.tex_col;
        entry.face    = in_item.wall_face;
        // zero distance counts as one
        entry.divisor = (in_item.distance == '0) ? DIST_W'(1) : in_item.distance;
        entry.num     = HD_NUM;
        entry.quo     = '0;
        entry.rem     = '0;
    end

    for (genvar s = 0; s < HD_STAGES; s++)
    begin : g_stage
        hdiv_t work;

        always_comb
        begin
            if (s == 0)
            begin
                work = entry;
            end
            else
            begin
                work = stage_reg[(s == 0) ? 0 : s - 1];
            end
            for (int i = 0; i < HD_STEPS; i++)
            begin
                if (s * HD_STEPS + i < FULLH_W)
                begin
                    work = hdiv_step(work);
                end
            end
            stage_next[s] = work;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign valid_next = {valid_reg[HD_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg[HD_STAGES-1];
    assign out_item  = stage_reg[HD_STAGES-1];

endmodule

FILE: hw/rtl/rcp_texrow.sv
module rcp_texrow (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  rcp_pkg::hdiv_t                    in_item,
    input  logic [rcp_pkg::COLOR_W-1:0]       ceiling_color,
    input  logic [rcp_pkg::COLOR_W-1:0]       floor_color,
    output logic                              out_valid,
    output rcp_pkg::out_item_t                out_item
);
    import rcp_pkg::*;

    localparam logic [FULLH_W-1:0]  SH_FULL = FULLH_W'(SCREEN_HEIGHT);
    localparam logic [H_W-1:0]      SH_VIS  = H_W'(SCREEN_HEIGHT);
    localparam logic [TEX_LOG2-1:0] TQ_MAX  = '1;

    function automatic tdiv_t tdiv_step(input tdiv_t x);
        logic [FULLH_W:0] r2;
        logic             ge;
        tdiv_t            y;
        y     = x;
        r2    = {x.rem, 1'b0};
        ge    = (r2 >= {1'b0, x.full_h});
        y.rem = ge ? FULLH_W'(r2 - {1'b0, x.full_h}) : r2[FULLH_W-1:0];
        y.quo = {x.quo[TEX_LOG2-2:0], ge};
        return y;
    endfunction

    // clip stage
    geo_t g1_reg;
    geo_t g1_next;
    logic g1_valid_reg;
    logic clip;

    always_comb
    begin
        clip            = (in_item.quo > SH_FULL);
        g1_next.column  = in_item.column;
        g1_next.row     = in_item.row;
        g1_next.tex_col = in_item.tex_col;
        g1_next.face    = in_item.face;
        g1_next.full_h  = in_item.quo;
        g1_next.vis_h   = clip ? SH_VIS : H_W'(in_item.quo);
        g1_next.skip    = clip ? ((in_item.quo - SH_FULL) >> 1) : '0;
        g1_next.offset  = (SH_VIS - g1_next.vis_h) >> 1;
    end

    // classify stage, then texture divider stages
    tdiv_t              td_reg  [TD_STAGES+1];
    tdiv_t              td_next [TD_STAGES+1];
    logic [TD_STAGES:0] td_valid_reg;

    logic [K_W-1:0] row_k;
    logic [K_W-1:0] off_k;
    logic [K_W-1:0] bottom_k;
    logic [K_W-1:0] k_val;

    always_comb
    begin
        row_k    = K_W'(g1_reg.row);
        off_k    = K_W'(g1_reg.offset);
        bottom_k = K_W'(g1_reg.vis_h) + off_k;
        k_val    = row_k - off_k + K_W'(g1_reg.skip);

        td_next[0].column  = g1_reg.column;
        td_next[0].row     = g1_reg.row;
        td_next[0].tex_col = g1_reg.tex_col;
        td_next[0].face    = g1_reg.face;
        td_next[0].full_h  = g1_reg.full_h;
        td_next[0].rem     = FULLH_W'(k_val);
        td_next[0].quo     = '0;
        // row at or past the full height saturates the texture row
        td_next[0].sat     = (k_val >= K_W'(g1_reg.full_h));
        if (row_k < off_k)
        begin
            td_next[0].src = SRC_CEILING;
        end
        else if (row_k > bottom_k)
        begin
            td_next[0].src = SRC_FLOOR;
        end
        else if (g1_reg.full_h == '0)
        begin
            td_next[0].src = SRC_NONE;
        end
        else
        begin
            td_next[0].src = SRC_WALL;
        end
    end

    for (genvar s = 1; s <= TD_STAGES; s++)
    begin : g_td
        tdiv_t work;

        always_comb
        begin
            work = td_reg[s-1];
            for (int i = 0; i < TD_STEPS; i++)
            begin
                if ((s - 1) * TD_STEPS + i < TEX_LOG2)
                begin
                    work = tdiv_step(work);
                end
            end
            td_next[s] = work;
        end
    end

    // result stage
    out_item_t out_reg;
    out_item_t out_next;
    logic      out_valid_reg;
    tdiv_t     last;

    always_comb
    begin
        last                  = td_reg[TD_STAGES];
        out_next.pixel_column = last.column;
        out_next.pixel_row    = last.row;
        out_next.source       = last.src;
        out_next.tex_col_out  = last.tex_col;
        out_next.face_out     = last.face;
        out_next.pixel_color  = '0;
        out_next.tex_row      = '0;
        case (last.src)
            SRC_CEILING: out_next.pixel_color = ceiling_color;
            SRC_FLOOR:   out_next.pixel_color = floor_color;
            SRC_WALL:    out_next.tex_row = last.sat ? TROW_W'(TQ_MAX) : TROW_W'(last.quo);
            default:     out_next.pixel_color = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_reg  <= g1_next;
            out_reg <= out_next;
            for (int s = 0; s <= TD_STAGES; s++)
            begin
                td_reg[s] <= td_next[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_valid_reg  <= 1'b0;
            td_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g1_valid_reg  <= in_valid;
            td_valid_reg  <= {td_valid_reg[TD_STAGES-1:0], g1_valid_reg};
            out_valid_reg <= td_valid_reg[TD_STAGES];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: hw/rtl/rcp_out_fifo.sv
module rcp_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  rcp_pkg::out_item_t push_item,
    output logic               room,
    rcp_out_if.source          pix_out
);
    import rcp_pkg::*;

    out_item_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    out_item_t  head;

    // room depends on fill alone, so ready upstream never waits on ready downstream
    assign room = (fill_reg != 2'd2);
    assign push = push_valid && room;
    assign pop  = pix_out.valid && pix_out.ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head                 = mem_reg[rd_ptr_reg];
    assign pix_out.valid        = (fill_reg != 2'd0);
    assign pix_out.pixel_column = head.pixel_column;
    assign pix_out.pixel_row    = head.pixel_row;
    assign pix_out.pixel_source = head.source;
    assign pix_out.pixel_color  = head.pixel_color;
    assign pix_out.tex_row      = head.tex_row;
    assign pix_out.tex_col_out  = head.tex_col_out;
    assign pix_out.face_out     = head.face_out;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("output buffer fill out of range");

    a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> fill_reg == $past(fill_reg) + 2'd1)
        else $error("output buffer lost a transfer");

    a_fill_down: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> fill_reg == $past(fill_reg) - 2'd1)
        else $error("output buffer repeated a transfer");

endmodule

FILE: hw/rtl/raycast_column_pixel_core.sv
// Raycaster column pixel core: one screen pixel in, one classified pixel out, one per
// clock while the buffer has room. Wall height is (SCREEN_HEIGHT << 5) / distance,
// worked out by a restoring divider spread over 8 stages of up to two quotient bits
// each (15 bits in all); geometry and row class take 2 stages, the texture row divider
// 3 stages at two bits each, and the result register one. A two-entry output buffer
// keeps input ready dependent only on its own fill, and a stall holds the whole
// pipeline. Colors are written through the cfg port; the user must do so only while
// idle, which the block does not enforce.
module raycast_column_pixel_core (
    input  logic                          clk,
    input  logic                          rst_n,
    rcp_in_if.sink                        pix_in,
    rcp_out_if.source                     pix_out,
    input  logic                          cfg_we,
    input  logic [rcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcp_pkg::COLOR_W-1:0]   cfg_data
);
    import rcp_pkg::*;

    logic [COLOR_W-1:0] ceiling_color_reg;
    logic [COLOR_W-1:0] floor_color_reg;
    logic               pipe_en;
    in_item_t           in_item;
    logic               hd_valid;
    hdiv_t              hd_item;
    logic               tr_valid;
    out_item_t          tr_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_color_reg <= '0;
            floor_color_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CEILING_COLOR: ceiling_color_reg <= cfg_data;
                CFG_FLOOR_COLOR:   floor_color_reg   <= cfg_data;
            endcase
        end
    end

    assign in_item.column    = pix_in.column;
    assign in_item.row       = pix_in.row;
    assign in_item.distance  = pix_in.distance;
    assign in_item.tex_col   = pix_in.tex_col;
    assign in_item.wall_face = pix_in.wall_face;
    assign pix_in.ready      = pipe_en;

    rcp_height_div u_height_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (pix_in.valid),
        .in_item   (in_item),
        .out_valid (hd_valid),
        .out_item  (hd_item)
    );

    rcp_texrow u_texrow (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (pipe_en),
        .in_valid      (hd_valid),
        .in_item       (hd_item),
        .ceiling_color (ceiling_color_reg),
        .floor_color   (floor_color_reg),
        .out_valid     (tr_valid),
        .out_item      (tr_item)
    );

    rcp_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (tr_valid),
        .push_item  (tr_item),
        .room       (pipe_en),
        .pix_out    (pix_out)
    );

    a_wall_no_color: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && (pix_out.pixel_source == SRC_WALL
                          || pix_out.pixel_source == SRC_NONE)
        |-> pix_out.pixel_color == '0)
        else $error("wall or no-draw pixel carries a color");

    a_flat_no_texrow: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && pix_out.pixel_source != SRC_WALL |-> pix_out.tex_row == '0)
        else $error("non-wall pixel carries a texture row");

endmodule

FILE: verif/pixel_class_checker.sv
`timescale 1ns / 100ps

module pixel_class_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    rcp_in_if                             pix_in,
    rcp_out_if                            pix_out,
    input  logic                          cfg_we,
    input  logic [rcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcp_pkg::COLOR_W-1:0]   cfg_data,
    output int                            in_flight,
    output int                            mismatches
);
    import rcp_pkg::*;

    logic [COLOR_W-1:0] ceiling_rgb = '0;
    logic [COLOR_W-1:0] floor_rgb   = '0;
    out_item_t          pending_pixels[$];
    int                 errors    = 0;
    int                 queued    = 0;

    assign mismatches = errors;
    assign in_flight  = queued;

    function automatic out_item_t classify_pixel(input in_item_t px,
                                                 input logic [COLOR_W-1:0] ceil_c,
                                                 input logic [COLOR_W-1:0] floor_c);
        int unsigned dist_val;
        int unsigned full_h;
        int unsigned vis_h;
        int unsigned skip;
        int unsigned offset;
        int unsigned tex;
        out_item_t   o;
        dist_val = (px.distance == '0) ? 1 : px.distance;
        full_h   = (SCREEN_HEIGHT << DIST_FRAC_BITS) / dist_val;
        vis_h    = full_h;
        skip     = 0;
        // tall wall: clip to the screen, remember how much of the texture top is cut
        if (full_h > SCREEN_HEIGHT)
        begin
            skip  = (full_h - SCREEN_HEIGHT) >> 1;
            vis_h = SCREEN_HEIGHT;
        end
        offset = (SCREEN_HEIGHT - vis_h) >> 1;

        o.pixel_column = px.column;
        o.pixel_row    = px.row;
        o.tex_col_out  = px.tex_col;
        o.face_out     = px.wall_face;
        o.pixel_color  = '0;
        o.tex_row      = '0;
        if (px.row < offset)
        begin
            o.source      = SRC_CEILING;
            o.pixel_color = ceil_c;
        end
        else if (px.row > vis_h + offset)
        begin
            o.source      = SRC_FLOOR;
            o.pixel_color = floor_c;
        end
        else if (full_h == 0)
        begin
            o.source = SRC_NONE;
        end
        else
        begin
            tex = ((px.row - offset + skip) << TEX_LOG2) / full_h;
            if (tex > (1 << TEX_LOG2) - 1)
                tex = (1 << TEX_LOG2) - 1;
            o.source  = SRC_WALL;
            o.tex_row = tex[TROW_W-1:0];
        end
        return o;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        in_item_t  px;
        if (rst_n)
        begin
            if (pix_out.valid && pix_out.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t unexpected pixel: expected none actual column %0d row %0d",
                             $time, pix_out.pixel_column, pix_out.pixel_row);
                    errors++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    check_field("pixel_column", want.pixel_column, pix_out.pixel_column);
                    check_field("pixel_row", want.pixel_row, pix_out.pixel_row);
                    check_field("source", want.source, pix_out.pixel_source);
                    check_field("pixel_color", want.pixel_color, pix_out.pixel_color);
                    check_field("tex_row", want.tex_row, pix_out.tex_row);
                    check_field("tex_col_out", want.tex_col_out, pix_out.tex_col_out);
                    check_field("face_out", want.face_out, pix_out.face_out);
                end
            end
            if (pix_in.valid && pix_in.ready)
            begin
                px.column    = pix_in.column;
                px.row       = pix_in.row;
                px.distance  = pix_in.distance;
                px.tex_col   = pix_in.tex_col;
                px.wall_face = pix_in.wall_face;
                pending_pixels.push_back(classify_pixel(px, ceiling_rgb, floor_rgb));
            end
            // color writes land at this edge, after the transfer above
            if (cfg_we)
            begin
                if (cfg_index == CFG_CEILING_COLOR)
                    ceiling_rgb = cfg_data;
                else if (cfg_index == CFG_FLOOR_COLOR)
                    floor_rgb = cfg_data;
            end
            queued <= pending_pixels.size();
        end
    end

endmodule

FILE: verif/raycast_column_pixel_core_test.sv
`timescale 1ns / 100ps

module raycast_column_pixel_core_test;
    import rcp_pkg::*;

    localparam int STALL_LIMIT    = 4000;
    localparam int ITEMS_PER_MIX  = 405;
    localparam int DRAIN_EVERY    = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CEILING_COLOR;
    logic [COLOR_W-1:0]   cfg_data = '0;

    int in_flight;
    int mismatches;
    int send_idle = 0;
    int stall_pct = 0;
    int sent_count = 0;
    int color_settings = 0;
    int quiet_cycles = 0;
    int send_idle_mix[4] = '{0, 80, 0, 23};
    int stall_mix[4]     = '{0, 0, 80, 23};

    rcp_in_if  pix_in_ch();
    rcp_out_if pix_out_ch();

    raycast_column_pixel_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in_ch),
        .pix_out   (pix_out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pixel_class_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in_ch),
        .pix_out    (pix_out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_flight  (in_flight),
        .mismatches (mismatches)
    );

    always #10 clk = ~clk;

    initial
    begin
        pix_in_ch.valid     = 1'b0;
        pix_in_ch.column    = '0;
        pix_in_ch.row       = '0;
        pix_in_ch.distance  = '0;
        pix_in_ch.tex_col   = '0;
        pix_in_ch.wall_face = '0;
        pix_out_ch.ready    = 1'b0;
    end

    always @(posedge clk)
        pix_out_ch.ready <= ($urandom_range(99) >= stall_pct);

    // no transfer on either side for too long means the block hung
    always @(posedge clk)
    begin
        if (!rst_n || (pix_in_ch.valid && pix_in_ch.ready)
                   || (pix_out_ch.valid && pix_out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("[raycast_column_pixel_core] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic in_item_t make_pixel(input int unsigned column, input int unsigned row,
                                            input int unsigned dist_val,
                                            input int unsigned tcol,
                                            input int unsigned face);
        in_item_t px;
        px.column    = column[COL_W-1:0];
        px.row       = row[ROW_W-1:0];
        px.distance  = dist_val[DIST_W-1:0];
        px.tex_col   = tcol[TCOL_W-1:0];
        px.wall_face = face[FACE_W-1:0];
        return px;
    endfunction

    // rows are aimed at the wall band and its edges most of the time
    function automatic in_item_t random_pixel();
        int unsigned dist_val;
        int unsigned full_h;
        int          lo;
        int          hi;
        int          r;
        case ($urandom_range(9))
            0, 1:    dist_val = $urandom_range(63);
            2:       dist_val = $urandom_range(65535);
            3:       dist_val = $urandom_range(65535, 16385);
            default: dist_val = ($urandom_range(16383) + 1) >> $urandom_range(9);
        endcase
        full_h = (SCREEN_HEIGHT << DIST_FRAC_BITS) / ((dist_val == 0) ? 1 : dist_val);
        if (full_h > SCREEN_HEIGHT)
            full_h = SCREEN_HEIGHT;
        lo = (SCREEN_HEIGHT - full_h) >> 1;
        hi = lo + full_h;
        case ($urandom_range(5))
            0: r = $urandom_range(511);
            1: r = lo - 1 + $urandom_range(1);
            2: r = hi + $urandom_range(1);
            default: r = $urandom_range(lo, (hi > 511) ? 511 : hi);
        endcase
        if (r < 0)
            r = 0;
        if (r > 511)
            r = 511;
        return make_pixel($urandom_range(1023), r, dist_val, $urandom_range(63),
                          $urandom_range(3));
    endfunction

    task automatic send_pixel(input in_item_t px);
        while ($urandom_range(99) < send_idle)
        begin
            pix_in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in_ch.valid     <= 1'b1;
        pix_in_ch.column    <= px.column;
        pix_in_ch.row       <= px.row;
        pix_in_ch.distance  <= px.distance;
        pix_in_ch.tex_col   <= px.tex_col;
        pix_in_ch.wall_face <= px.wall_face;
        @(posedge clk);
        while (!pix_in_ch.ready)
            @(posedge clk);
        sent_count++;
    endtask

    // drop valid and let the last transfer be counted before waiting on it
    task automatic drain_pipeline();
        pix_in_ch.valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    task automatic write_colors(input logic [COLOR_W-1:0] ceil_c,
                                input logic [COLOR_W-1:0] floor_c);
        drain_pipeline();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CEILING_COLOR;
        cfg_data  <= ceil_c;
        @(posedge clk);
        cfg_index <= CFG_FLOOR_COLOR;
        cfg_data  <= floor_c;
        @(posedge clk);
        cfg_we <= 1'b0;
        color_settings++;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_colors(24'hFFFFFF, 24'h000000);
        send_pixel(make_pixel(0, 0, 0, 0, 0));          // zero distance
        send_pixel(make_pixel(1023, 511, 0, 63, 3));
        send_pixel(make_pixel(5, 255, 1, 1, 1));        // tallest clipped wall
        send_pixel(make_pixel(6, 511, 1, 2, 2));
        send_pixel(make_pixel(7, 0, 31, 4, 3));
        send_pixel(make_pixel(8, 0, 32, 8, 0));         // wall exactly screen high
        send_pixel(make_pixel(9, 511, 32, 16, 1));
        send_pixel(make_pixel(10, 511, 33, 32, 2));
        send_pixel(make_pixel(11, 7, 33, 62, 3));       // last ceiling row
        send_pixel(make_pixel(12, 8, 33, 61, 0));       // first wall row
        send_pixel(make_pixel(13, 504, 33, 59, 1));     // bottom row, texture row saturates
        send_pixel(make_pixel(14, 505, 33, 55, 2));     // first floor row
        send_pixel(make_pixel(15, 255, 16384, 47, 3));  // one-pixel wall
        send_pixel(make_pixel(16, 256, 16384, 31, 0));
        send_pixel(make_pixel(17, 257, 16384, 21, 1));
        send_pixel(make_pixel(18, 256, 16385, 42, 2));  // zero height, no draw
        send_pixel(make_pixel(19, 255, 16385, 10, 3));
        send_pixel(make_pixel(20, 257, 16385, 5, 0));
        send_pixel(make_pixel(21, 256, 65535, 63, 1));
        send_pixel(make_pixel(512, 100, 1000, 33, 2));
        send_pixel(make_pixel(341, 300, 4096, 17, 3));

        for (int mix = 0; mix < 4; mix++)
        begin
            case (mix)
                0:       write_colors(24'h000000, 24'hFFFFFF);
                3:       write_colors(24'h5AA55A, 24'hA55AA5);
                default: write_colors($urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF));
            endcase
            send_idle = send_idle_mix[mix];
            stall_pct = stall_mix[mix];
            for (int i = 0; i < ITEMS_PER_MIX; i++)
            begin
                send_pixel(random_pixel());
                if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
                    drain_pipeline();
            end
        end

        stall_pct = 0;
        drain_pipeline();
        repeat (30) @(posedge clk);
        $display("covered %0d pixels under four flow-control mixes", sent_count);
        $display("with %0d ceiling/floor color settings, %0d mismatches",
                 color_settings, mismatches);
        if (mismatches == 0)
            $display("[raycast_column_pixel_core] OK");
        else
            $display("[raycast_column_pixel_core] ERROR");
        $finish;
    end

endmodule
